/* hdl/edf_pkg.sv */
package edf_pkg;

   // Field widths of the words and of the slot table
   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int FACTOR_W          = 4;
   localparam int TAG_W             = 8;
   localparam int TIME_W            = 32;
   localparam int BURST_W           = 16;
   localparam int DEADLINE_W        = 36;
   localparam int PROD_W            = FACTOR_W + BURST_W;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(2);
   localparam logic [TIME_W-1:0]   TIME_MAX     = '1;

   // Function codes of a request word
   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED   = 3'd0,
      STATUS_FULL       = 3'd1,
      STATUS_RAN        = 3'd2,
      STATUS_IDLE       = 3'd3,
      STATUS_ZERO_BURST = 3'd4
   } status_type;

   typedef struct packed {
      logic               func;
      logic [TAG_W-1:0]   task_tag;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [TAG_W-1:0]   running_tag;
      logic               completed;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  waiting;
      logic [TIME_W-1:0]  time_now;
   } rsp_type;

   // One entry of the slot memory
   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic [TIME_W-1:0]     arrival;
      logic [BURST_W-1:0]    burst;
      logic [BURST_W-1:0]    remaining;
      logic [DEADLINE_W-1:0] deadline;
   } entry_type;

   // Which kind of response word the datapath is to build
   typedef enum logic [1:0] {
      RES_ACCEPT,
      RES_FULL,
      RES_ZERO,
      RES_TICK
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FIND,
      S_SCAN,
      S_DRAIN,
      S_APPLY,
      S_REPORT
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic    load_req;
      logic    clear;
      logic    read;
      logic    advance;
      logic    fill;
      logic    apply;
      logic    emit;
      res_type res;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_tick;
      logic zero_burst;
      logic slot_free;
      logic scan_last;
   } stat_type;

endpackage

/* hdl/edf_preemptive_scheduler.sv */
// Preemptive earliest-deadline-first scheduler over NUM_SLOTS task slots. A request word
// is taken when start is high and busy is low; exactly one response word follows, shown
// on rsp_word for a single cycle with rsp_valid high, in the same cycle as busy falls. The
// receiver cannot hold responses off, so it must take every word as it comes. A submit
// with zero burst is answered straight from the decode state; any other submit walks the
// valid bits one per cycle from slot 0 and stops at the lowest free slot, or answers full
// after the last slot. A tick reads the slot memory one entry per cycle for the deadline
// compare; then a drain state compares the last read, an apply state writes back the
// chosen task and a report state forms the response. A new request word can be taken
// in the same cycle as the response word appears. Slot contents need no clearing after
// reset; the valid bits alone are cleared.
module edf_preemptive_scheduler #(
   parameter int NUM_SLOTS = edf_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  edf_pkg::req_type             req_word,
   input  logic                         csr_we,
   input  logic [edf_pkg::FACTOR_W-1:0] csr_wdata,
   output logic                         rsp_valid,
   output edf_pkg::rsp_type             rsp_word
);
   import edf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   edf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   edf_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // A response word only ever follows a busy cycle.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response word without a request in progress");

   // Each request gives a single one-cycle response word.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // Taking a request word always makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request word taken without going busy");

   // Completion is only reported for a tick that ran a task.
   a_completed_ran: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.completed) |-> (rsp_word.status == STATUS_RAN))
      else $error("completion reported without a task run");

endmodule

/* hdl/edf_ctrl.sv */
module edf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  edf_pkg::stat_type stat,
   output logic              busy,
   output edf_pkg::cmd_type  cmd
);
   import edf_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res  = RES_ACCEPT;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_tick) begin
               state_in = S_SCAN;
            end else if (stat.zero_burst) begin
               cmd.emit = 1'b1;
               cmd.res  = RES_ZERO;
               state_in = S_IDLE;
            end else begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            // Walk the valid bits until the lowest free slot turns up or the last slot is found full.
            if (stat.slot_free) begin
               cmd.fill = 1'b1;
               cmd.emit = 1'b1;
               cmd.res  = RES_ACCEPT;
               state_in = S_IDLE;
            end else if (stat.scan_last) begin
               cmd.emit = 1'b1;
               cmd.res  = RES_FULL;
               state_in = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.read    = 1'b1;
            cmd.advance = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last memory read is compared in this cycle.
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_REPORT;
         end
         S_REPORT: begin
            cmd.emit = 1'b1;
            cmd.res  = RES_TICK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/edf_dp.sv */
module edf_dp #(
   parameter int NUM_SLOTS = edf_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  edf_pkg::cmd_type               cmd,
   output edf_pkg::stat_type              stat,
   input  edf_pkg::req_type               req_word,
   input  logic                           csr_we,
   input  logic [edf_pkg::FACTOR_W-1:0]   csr_wdata,
   output logic                           rsp_valid,
   output edf_pkg::rsp_type               rsp_word
);
   import edf_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   logic [FACTOR_W-1:0]   factor_ff;
   req_type               req_ff;
   logic [PROD_W-1:0]     prod;
   logic [DEADLINE_W-1:0] deadline_ff, deadline_in;
   logic [NUM_SLOTS-1:0]  valid_ff;
   entry_type             mem [NUM_SLOTS];
   logic [IDX_W-1:0]      idx_ff, rd_idx_ff, best_idx_ff, wr_idx;
   entry_type             rd_ff, best_ff, wr_entry;
   logic                  rd_vld_ff, best_found_ff;
   logic [TIME_W-1:0]     time_ff, time_nx_ff, time_nx_in, turn_ff, wait_in;
   logic                  comp_ff;
   logic [BURST_W-1:0]    rem_dec;
   logic                  cand_ok, cand_better, mem_we, last_unit;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   // Deadline factor register
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_we) begin
         factor_ff <= csr_wdata;
      end
   end

   // Request word capture and the deadline of a submitted task
   assign prod        = PROD_W'(factor_ff) * PROD_W'(req_ff.burst);
   assign deadline_in = DEADLINE_W'(req_ff.arrival) + DEADLINE_W'(prod);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
      deadline_ff <= deadline_in;
   end

   // Slot index counter shared by the free-slot search and the tick scan
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.clear) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Slot memory: one write port, one registered read port
   assign rem_dec   = best_ff.remaining - 1'b1;
   assign last_unit = (rem_dec == '0);
   assign mem_we    = cmd.fill || (cmd.apply && best_found_ff);
   assign wr_idx    = cmd.fill ? idx_ff : best_idx_ff;

   always_comb begin
      if (cmd.fill) begin
         wr_entry.tag       = req_ff.task_tag;
         wr_entry.arrival   = req_ff.arrival;
         wr_entry.burst     = req_ff.burst;
         wr_entry.remaining = req_ff.burst;
         wr_entry.deadline  = deadline_ff;
      end else begin
         wr_entry           = best_ff;
         wr_entry.remaining = rem_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
      if (cmd.read) begin
         rd_ff     <= mem[idx_ff];
         rd_idx_ff <= idx_ff;
      end
   end

   // Valid bits: set on a fill, cleared when a task finishes its last unit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.fill) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.apply && best_found_ff && last_unit) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // Earliest-deadline compare on each word read back during the scan.
   // Strict comparisons keep the lower slot on a full tie.
   assign cand_ok = rd_vld_ff && valid_ff[rd_idx_ff] && (rd_ff.remaining != '0)
                    && (rd_ff.arrival <= time_ff);
   assign cand_better = !best_found_ff
                        || (rd_ff.deadline < best_ff.deadline)
                        || ((rd_ff.deadline == best_ff.deadline)
                            && (rd_ff.remaining < best_ff.remaining));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.clear) begin
            best_found_ff <= 1'b0;
         end else if (cand_ok && cand_better) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cand_ok && cand_better) begin
         best_ff     <= rd_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // Time counter with its saturating successor held ready
   assign time_nx_in = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         time_nx_ff <= TIME_W'(1);
      end else begin
         time_nx_ff <= time_nx_in;
         if (cmd.apply) begin
            time_ff <= time_nx_ff;
         end
      end
   end

   // Completion and turnaround, taken when the chosen task runs its unit
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         comp_ff <= best_found_ff && last_unit;
         turn_ff <= time_nx_ff - best_ff.arrival;
      end
   end

   // Waiting time, clamped at zero when the time counter has saturated
   assign wait_in = (turn_ff >= TIME_W'(best_ff.burst)) ?
                    (turn_ff - TIME_W'(best_ff.burst)) : '0;

   // Response word
   always_comb begin
      rsp_in          = '0;
      rsp_in.status   = STATUS_ACCEPTED;
      rsp_in.time_now = time_ff;
      case (cmd.res)
         RES_ACCEPT: begin
            rsp_in.status = STATUS_ACCEPTED;
         end
         RES_FULL: begin
            rsp_in.status = STATUS_FULL;
         end
         RES_ZERO: begin
            rsp_in.status = STATUS_ZERO_BURST;
         end
         RES_TICK: begin
            if (best_found_ff) begin
               rsp_in.status      = STATUS_RAN;
               rsp_in.running_tag = best_ff.tag;
               rsp_in.completed   = comp_ff;
               if (comp_ff) begin
                  rsp_in.turnaround = turn_ff;
                  rsp_in.waiting    = wait_in;
               end
            end else begin
               rsp_in.status = STATUS_IDLE;
            end
         end
         default: begin
            rsp_in.status = STATUS_ACCEPTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Status back to the controller
   assign stat.is_tick    = (req_ff.func == FUNC_TICK);
   assign stat.zero_burst = (req_ff.burst == '0);
   assign stat.slot_free  = !valid_ff[idx_ff];
   assign stat.scan_last  = (idx_ff == LAST_IDX);

endmodule
